// ===== rtl/core/mcfsm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the multicycle main control state machine.
package mcfsm_pkg;

  // One-hot state codes
  typedef enum logic [12:0] {
    S_FETCH   = 13'b0_0000_0000_0001,
    S_DECODE  = 13'b0_0000_0000_0010,
    S_MADDR   = 13'b0_0000_0000_0100,
    S_MREAD   = 13'b0_0000_0000_1000,
    S_MWB     = 13'b0_0000_0001_0000,
    S_MWRITE  = 13'b0_0000_0010_0000,
    S_REXEC   = 13'b0_0000_0100_0000,
    S_RWB     = 13'b0_0000_1000_0000,
    S_BEQ     = 13'b0_0001_0000_0000,
    S_IEXEC   = 13'b0_0010_0000_0000,
    S_IWB     = 13'b0_0100_0000_0000,
    S_JAL     = 13'b0_1000_0000_0000,
    S_BNE     = 13'b1_0000_0000_0000
  } state_t;

  // Numbers reported on the state field
  localparam logic [3:0] SN_FETCH  = 4'd0;
  localparam logic [3:0] SN_DECODE = 4'd1;
  localparam logic [3:0] SN_MADDR  = 4'd2;
  localparam logic [3:0] SN_MREAD  = 4'd3;
  localparam logic [3:0] SN_MWB    = 4'd4;
  localparam logic [3:0] SN_MWRITE = 4'd5;
  localparam logic [3:0] SN_REXEC  = 4'd6;
  localparam logic [3:0] SN_RWB    = 4'd7;
  localparam logic [3:0] SN_BEQ    = 4'd8;
  localparam logic [3:0] SN_IEXEC  = 4'd9;
  localparam logic [3:0] SN_IWB    = 4'd10;
  localparam logic [3:0] SN_JAL    = 4'd11;
  localparam logic [3:0] SN_BNE    = 4'd12;

  // Opcode classes
  localparam logic [3:0] OP_LW   = 4'd0;
  localparam logic [3:0] OP_SW   = 4'd1;
  localparam logic [3:0] OP_ADD  = 4'd2;
  localparam logic [3:0] OP_SUB  = 4'd3;
  localparam logic [3:0] OP_AND  = 4'd4;
  localparam logic [3:0] OP_OR   = 4'd5;
  localparam logic [3:0] OP_XOR  = 4'd6;
  localparam logic [3:0] OP_BEQ  = 4'd7;
  localparam logic [3:0] OP_ADDI = 4'd8;
  localparam logic [3:0] OP_ORI  = 4'd9;
  localparam logic [3:0] OP_XORI = 4'd10;
  localparam logic [3:0] OP_JAL  = 4'd11;
  localparam logic [3:0] OP_BNE  = 4'd12;

  // ALU B source
  localparam logic [1:0] BSEL_REGB  = 2'b00;
  localparam logic [1:0] BSEL_FOUR  = 2'b01;
  localparam logic [1:0] BSEL_IMM   = 2'b10;
  localparam logic [1:0] BSEL_IMMSH = 2'b11;

  // ALU operation class
  localparam logic [1:0] ALU_ADD   = 2'b00;
  localparam logic [1:0] ALU_SUB   = 2'b01;
  localparam logic [1:0] ALU_FUNCT = 2'b10;
  localparam logic [1:0] ALU_IMM   = 2'b11;

  // PC source
  localparam logic [1:0] PC_ALU    = 2'b00;
  localparam logic [1:0] PC_ALUOUT = 2'b01;
  localparam logic [1:0] PC_JUMP   = 2'b10;

  // Write enables
  localparam logic [2:0] WE_NONE = 3'b000;
  localparam logic [2:0] WE_REG  = 3'b001;
  localparam logic [2:0] WE_MEM  = 3'b010;
  localparam logic [2:0] WE_PC   = 3'b100;

  // Branch kind
  localparam logic [1:0] BR_NONE = 2'b00;
  localparam logic [1:0] BR_EQ   = 2'b01;
  localparam logic [1:0] BR_NE   = 2'b10;

  // Control word for one transaction
  typedef struct packed {
    logic [3:0] state_num;
    logic       addr_from_alu_out;
    logic       alu_in_a_sel;
    logic [1:0] alu_in_b_sel;
    logic [1:0] alu_operation;
    logic [1:0] next_pc_sel;
    logic       dest_is_rd;
    logic       writeback_from_mem;
    logic [2:0] write_enables;
    logic [1:0] branch_kind;
    logic       illegal_opcode;
  } ctl_t;

endpackage

// ===== rtl/core/multicycle_cpu_main_control_fsm.sv =====
`timescale 1ns / 1ps
// Top level of the multicycle processor main control state machine.
//
// Each input transaction stands for one clock edge of the processor: it
// carries a reset request and the opcode class of the current instruction.
// For every input transaction the block returns exactly one result
// transaction holding the current state's number and its Moore control
// signals, then advances the state (fetch, decode, memory address, load
// read, load writeback, store, R-type execute/writeback, BEQ, immediate
// execute/writeback, JAL, BNE). A reset request reports all zeros and
// returns to fetch. An unsupported opcode seen in decode raises
// illegal_opcode and returns to fetch. Rate: one transaction per cycle
// unless stalled; the result appears in the cycle after acceptance, in
// the single result register behind the state register and output decode.
// in_stall is raised only while a result is held and the output side stalls.
module multicycle_cpu_main_control_fsm (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_reset_request,
  input  logic [3:0] in_op_class,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_current_state,
  output logic       out_addr_from_alu_out,
  output logic       out_alu_in_a_sel,
  output logic [1:0] out_alu_in_b_sel,
  output logic [1:0] out_alu_operation,
  output logic [1:0] out_next_pc_sel,
  output logic       out_dest_is_rd,
  output logic       out_writeback_from_mem,
  output logic [2:0] out_write_enables,
  output logic [1:0] out_branch_kind,
  output logic       out_illegal_opcode
);

  mcfsm_pkg::state_t state_r;
  mcfsm_pkg::state_t state_nxt;
  mcfsm_pkg::state_t dec_nxt;
  mcfsm_pkg::ctl_t   dec_ctl;
  mcfsm_pkg::ctl_t   res_nxt;
  mcfsm_pkg::ctl_t   res_r;
  logic              out_valid_r;
  logic              in_acc;

  // Input may enter whenever the result register is free or being drained
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  mcfsm_ctrl_dec u_dec (
    .state     (state_r),
    .op_class  (in_op_class),
    .ctl       (dec_ctl),
    .state_nxt (dec_nxt)
  );

  // Reset request masks every control field and forces fetch
  always_comb begin
    if (in_reset_request) begin
      res_nxt   = '0;
      state_nxt = mcfsm_pkg::S_FETCH;
    end else begin
      res_nxt   = dec_ctl;
      state_nxt = dec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcfsm_pkg::S_FETCH;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        state_r <= state_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_current_state      = res_r.state_num;
  assign out_addr_from_alu_out  = res_r.addr_from_alu_out;
  assign out_alu_in_a_sel       = res_r.alu_in_a_sel;
  assign out_alu_in_b_sel       = res_r.alu_in_b_sel;
  assign out_alu_operation      = res_r.alu_operation;
  assign out_next_pc_sel        = res_r.next_pc_sel;
  assign out_dest_is_rd         = res_r.dest_is_rd;
  assign out_writeback_from_mem = res_r.writeback_from_mem;
  assign out_write_enables      = res_r.write_enables;
  assign out_branch_kind        = res_r.branch_kind;
  assign out_illegal_opcode     = res_r.illegal_opcode;

  // State register stays one-hot
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  // Illegal flag only ever comes from decode
  a_illegal_in_decode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.illegal_opcode |-> res_r.state_num == mcfsm_pkg::SN_DECODE)
    else $error("illegal opcode flagged outside decode");

  // Reset request returns to fetch
  a_reset_req_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_reset_request |=> state_r == mcfsm_pkg::S_FETCH)
    else $error("reset request did not return to fetch");

  // Held result is never overwritten
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(res_r))
    else $error("stalled result changed");

  // An accepted fetch without a reset request advances to decode
  a_decode_from_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_reset_request && state_r == mcfsm_pkg::S_FETCH
      |=> state_r == mcfsm_pkg::S_DECODE)
    else $error("fetch did not advance to decode");

endmodule

// ===== rtl/core/mcfsm_ctrl_dec.sv =====
`timescale 1ns / 1ps
// Moore output and next-state decode of the main control state machine.
module mcfsm_ctrl_dec (
  input  mcfsm_pkg::state_t state,
  input  logic [3:0]        op_class,
  output mcfsm_pkg::ctl_t   ctl,
  output mcfsm_pkg::state_t state_nxt
);

  always_comb begin
    ctl       = '0;
    state_nxt = mcfsm_pkg::S_FETCH;
    unique case (state)
      mcfsm_pkg::S_FETCH: begin
        ctl.state_num     = mcfsm_pkg::SN_FETCH;
        ctl.alu_in_b_sel  = mcfsm_pkg::BSEL_FOUR;
        ctl.write_enables = mcfsm_pkg::WE_PC;
        state_nxt         = mcfsm_pkg::S_DECODE;
      end
      mcfsm_pkg::S_DECODE: begin
        ctl.state_num    = mcfsm_pkg::SN_DECODE;
        ctl.alu_in_b_sel = mcfsm_pkg::BSEL_IMMSH;
        unique case (op_class) inside
          mcfsm_pkg::OP_LW, mcfsm_pkg::OP_SW:
            state_nxt = mcfsm_pkg::S_MADDR;
          mcfsm_pkg::OP_ADD, mcfsm_pkg::OP_SUB, mcfsm_pkg::OP_AND,
          mcfsm_pkg::OP_OR, mcfsm_pkg::OP_XOR:
            state_nxt = mcfsm_pkg::S_REXEC;
          mcfsm_pkg::OP_BEQ:
            state_nxt = mcfsm_pkg::S_BEQ;
          mcfsm_pkg::OP_ADDI, mcfsm_pkg::OP_ORI, mcfsm_pkg::OP_XORI:
            state_nxt = mcfsm_pkg::S_IEXEC;
          mcfsm_pkg::OP_JAL:
            state_nxt = mcfsm_pkg::S_JAL;
          mcfsm_pkg::OP_BNE:
            state_nxt = mcfsm_pkg::S_BNE;
          default: begin
            // unsupported opcode: flag it and refetch
            ctl.illegal_opcode = 1'b1;
            state_nxt          = mcfsm_pkg::S_FETCH;
          end
        endcase
      end
      mcfsm_pkg::S_MADDR: begin
        ctl.state_num    = mcfsm_pkg::SN_MADDR;
        ctl.alu_in_a_sel = 1'b1;
        ctl.alu_in_b_sel = mcfsm_pkg::BSEL_IMM;
        if (op_class == mcfsm_pkg::OP_LW) begin
          state_nxt = mcfsm_pkg::S_MREAD;
        end else if (op_class == mcfsm_pkg::OP_SW) begin
          state_nxt = mcfsm_pkg::S_MWRITE;
        end else begin
          state_nxt = mcfsm_pkg::S_FETCH;
        end
      end
      mcfsm_pkg::S_MREAD: begin
        ctl.state_num         = mcfsm_pkg::SN_MREAD;
        ctl.addr_from_alu_out = 1'b1;
        state_nxt             = mcfsm_pkg::S_MWB;
      end
      mcfsm_pkg::S_MWB: begin
        ctl.state_num          = mcfsm_pkg::SN_MWB;
        ctl.writeback_from_mem = 1'b1;
        ctl.write_enables      = mcfsm_pkg::WE_REG;
      end
      mcfsm_pkg::S_MWRITE: begin
        ctl.state_num         = mcfsm_pkg::SN_MWRITE;
        ctl.addr_from_alu_out = 1'b1;
        ctl.write_enables     = mcfsm_pkg::WE_MEM;
      end
      mcfsm_pkg::S_REXEC: begin
        ctl.state_num     = mcfsm_pkg::SN_REXEC;
        ctl.alu_in_a_sel  = 1'b1;
        ctl.alu_operation = mcfsm_pkg::ALU_FUNCT;
        state_nxt         = mcfsm_pkg::S_RWB;
      end
      mcfsm_pkg::S_RWB: begin
        ctl.state_num     = mcfsm_pkg::SN_RWB;
        ctl.dest_is_rd    = 1'b1;
        ctl.write_enables = mcfsm_pkg::WE_REG;
      end
      mcfsm_pkg::S_BEQ: begin
        ctl.state_num     = mcfsm_pkg::SN_BEQ;
        ctl.alu_in_a_sel  = 1'b1;
        ctl.alu_operation = mcfsm_pkg::ALU_SUB;
        ctl.next_pc_sel   = mcfsm_pkg::PC_ALUOUT;
        ctl.branch_kind   = mcfsm_pkg::BR_EQ;
      end
      mcfsm_pkg::S_IEXEC: begin
        ctl.state_num     = mcfsm_pkg::SN_IEXEC;
        ctl.alu_in_a_sel  = 1'b1;
        ctl.alu_in_b_sel  = mcfsm_pkg::BSEL_IMM;
        ctl.alu_operation = mcfsm_pkg::ALU_IMM;
        state_nxt         = mcfsm_pkg::S_IWB;
      end
      mcfsm_pkg::S_IWB: begin
        ctl.state_num     = mcfsm_pkg::SN_IWB;
        ctl.write_enables = mcfsm_pkg::WE_REG;
      end
      mcfsm_pkg::S_JAL: begin
        ctl.state_num     = mcfsm_pkg::SN_JAL;
        ctl.next_pc_sel   = mcfsm_pkg::PC_JUMP;
        ctl.write_enables = mcfsm_pkg::WE_PC;
      end
      mcfsm_pkg::S_BNE: begin
        ctl.state_num     = mcfsm_pkg::SN_BNE;
        ctl.alu_in_a_sel  = 1'b1;
        ctl.alu_operation = mcfsm_pkg::ALU_SUB;
        ctl.next_pc_sel   = mcfsm_pkg::PC_ALUOUT;
        ctl.branch_kind   = mcfsm_pkg::BR_NE;
      end
      default: begin
        ctl       = '0;
        state_nxt = mcfsm_pkg::S_FETCH;
      end
    endcase
  end

endmodule
